>>> rtl/idct_pkg.sv
// Shared types, constants and the basis-factor function of the 8x8 inverse DCT.
// Used by the controller, the datapath and the top level.
package idct_pkg;

  // Block geometry, fixed at the standard 8x8 block.
  localparam int unsigned BLK    = 8;
  localparam int unsigned K_W    = $clog2(BLK);
  localparam int unsigned IDX_W  = 2 * K_W;
  localparam int unsigned NCOEF  = BLK * BLK;

  // Datapath widths: coefficient, Q1.14 factor, row-pass result, accumulator.
  localparam int unsigned COEF_W = 16;
  localparam int unsigned FAC_W  = 16;
  localparam int unsigned TMP_W  = 35;
  localparam int unsigned PROD_W = TMP_W + FAC_W;
  localparam int unsigned ACC_W  = PROD_W + K_W;
  localparam int unsigned SHIFT  = 30;
  localparam int unsigned SHR_W  = ACC_W - SHIFT;

  // Controller states.
  typedef enum logic [2:0] {
    S_LOAD,
    S_ROW_RUN,
    S_ROW_DRAIN,
    S_COL_WAIT,
    S_COL_RUN,
    S_COL_DRAIN
  } state_e;

  // Command from controller to datapath.
  typedef struct packed {
    logic             load_we;
    logic [IDX_W-1:0] load_addr;
    logic             issue;
    logic             col_pass;
    logic [IDX_W-1:0] grp;
    logic [K_W-1:0]   k;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  // Q1.14 magnitude of cos(r*pi/16) for r from 0 to 8.
  function automatic logic [FAC_W-1:0] cos_mag(input logic [3:0] r);
    logic [FAC_W-1:0] m;
    unique case (r)
      4'd0:    m = 16'd16384;
      4'd1:    m = 16'd16069;
      4'd2:    m = 16'd15137;
      4'd3:    m = 16'd13623;
      4'd4:    m = 16'd11585;
      4'd5:    m = 16'd9102;
      4'd6:    m = 16'd6270;
      4'd7:    m = 16'd3196;
      default: m = 16'd0;
    endcase
    return m;
  endfunction

  // c(q)*cos((2p+1)q*pi/16) in signed Q1.14.
  function automatic logic signed [FAC_W-1:0] basis_f(input logic [K_W-1:0] p,
                                                      input logic [K_W-1:0] q);
    logic [8:0]       prod;
    logic [4:0]       ph;
    logic [3:0]       r;
    logic             neg;
    logic [FAC_W-1:0] mag;
    prod = ({5'd0, p, 1'b1}) * {6'd0, q};
    ph   = prod[4:0];
    neg  = 1'b0;
    r    = 4'd0;
    if (ph < 5'd8) begin
      r = ph[3:0];
    end else if (ph < 5'd16) begin
      r   = 4'(5'd16 - ph);
      neg = 1'b1;
    end else if (ph < 5'd24) begin
      r   = 4'(ph - 5'd16);
      neg = 1'b1;
    end else begin
      r = 4'(6'd32 - {1'b0, ph});
    end
    mag = cos_mag(r);
    if (q == '0) begin
      return 16'sd11585;
    end
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

>>> rtl/idct_2d_block_unit.sv
// Top level of the 8x8 inverse DCT block.
// Depends on idct_pkg, idct_ctrl and idct_dp.
//
// Usage: 64 dequantized coefficients arrive on the input channel
// (in_valid_i/in_ready_o, coefficient_i) in row-major order, row index the
// vertical frequency. After the 64th beat the block computes the separable
// transform: a row pass of 512 products into a transpose store, then a column
// pass that yields one sample per 8 products. Samples leave on the output
// channel (out_valid_o/out_ready_i, sample_o, last_sample_o) in row-major
// order, last_sample_o marking the 64th. Each sample is the exact sum shifted
// right by 30 with floor, plus 128, saturated to signed 16 bits.
// One shared multiply-accumulate pipeline serves both passes and sets the rate.
// Input is taken only while loading, so the next block is accepted only after
// the column pass of the current one has ended.
// A stalled receiver holds the pending sample and the column pass waits.
// Reset empties the output register and restarts loading at the first
// coefficient; the stores need no clearing.
module idct_2d_block_unit import idct_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] coefficient_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_o,
  output logic               last_sample_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  idct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  idct_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .coefficient_i (coefficient_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_o      (sample_o),
    .last_sample_o (last_sample_o)
  );

endmodule

>>> rtl/idct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module idct_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/idct_ctrl.sv
// Sequencer of the inverse DCT: loading, row pass, column pass.
// Depends on idct_pkg.
module idct_ctrl import idct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] load_q, load_d;
  logic [IDX_W-1:0] grp_q, grp_d;
  logic [K_W-1:0]   k_q, k_d;
  logic [1:0]       drain_q, drain_d;
  logic             in_acc;
  logic             grp_end;

  assign in_acc  = in_valid_i && in_ready_o;
  assign grp_end = (k_q == K_W'(BLK - 1));

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    load_d  = load_q;
    grp_d   = grp_q;
    k_d     = k_q;
    drain_d = drain_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          load_d = load_q + 1'b1;
          if (load_q == IDX_W'(NCOEF - 1)) begin
            state_d = S_ROW_RUN;
            grp_d   = '0;
            k_d     = '0;
          end
        end
      end
      S_ROW_RUN, S_COL_RUN: begin
        k_d = k_q + 1'b1;
        if (grp_end) begin
          if (state_q == S_ROW_RUN) begin
            grp_d = grp_q + 1'b1;
            if (grp_q == IDX_W'(NCOEF - 1)) begin
              state_d = S_ROW_DRAIN;
              drain_d = '0;
            end
          end else begin
            state_d = S_COL_DRAIN;
            drain_d = '0;
          end
        end
      end
      S_ROW_DRAIN: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == 2'd2) begin
          state_d = S_COL_WAIT;
        end
      end
      S_COL_WAIT: begin
        if (!status_i.out_busy) begin
          state_d = S_COL_RUN;
          k_d     = '0;
        end
      end
      S_COL_DRAIN: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == 2'd2) begin
          grp_d   = grp_q + 1'b1;
          state_d = (grp_q == IDX_W'(NCOEF - 1)) ? S_LOAD : S_COL_WAIT;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Outputs to the datapath.
  always_comb begin
    in_ready_o      = (state_q == S_LOAD);
    cmd_o.load_we   = in_acc;
    cmd_o.load_addr = load_q;
    cmd_o.issue     = (state_q == S_ROW_RUN) || (state_q == S_COL_RUN);
    cmd_o.col_pass  = (state_q == S_COL_RUN);
    cmd_o.grp       = grp_q;
    cmd_o.k         = k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      load_q  <= '0;
      grp_q   <= '0;
      k_q     <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      grp_q   <= grp_d;
      k_q     <= k_d;
      drain_q <= drain_d;
    end
  end

  // A column group only starts while the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COL_RUN && k_q == '0) |-> !status_i.out_busy)
    else $error("column group started with output busy");

  // The load counter is back at zero whenever the row pass starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROW_RUN && $past(state_q) == S_LOAD) |-> (load_q == '0))
    else $error("load counter not wrapped at row pass start");

endmodule

>>> rtl/idct_dp.sv
// Datapath of the inverse DCT: coefficient and transpose stores, one
// multiply-accumulate pipeline, rounding, saturation and output register.
// Depends on idct_pkg and idct_ram.
module idct_dp import idct_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_status_t               status_o,
  input  logic signed [COEF_W-1:0] coefficient_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [15:0]       sample_o,
  output logic                     last_sample_o
);

  logic [IDX_W-1:0]         coef_raddr, tmp_raddr;
  logic [COEF_W-1:0]        coef_rdata;
  logic [TMP_W-1:0]         tmp_rdata;
  logic                     tmp_we;
  logic [TMP_W-1:0]         tmp_wdata;
  logic signed [FAC_W-1:0]  fac;

  logic                     vld1_q, col1_q, vld2_q, col2_q;
  logic [IDX_W-1:0]         grp1_q, grp2_q;
  logic [K_W-1:0]           k1_q, k2_q;
  logic signed [FAC_W-1:0]  fac1_q;
  logic signed [TMP_W-1:0]  mdata;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, sum;
  logic                     fin;
  logic signed [SHR_W-1:0]  shr;
  logic signed [SHR_W:0]    lvl;
  logic signed [15:0]       sat;
  logic                     out_valid_q, last_q;
  logic signed [15:0]       sample_q;

  // Read addresses and basis factor for the issued product.
  always_comb begin
    coef_raddr = {cmd_i.grp[IDX_W-1:K_W], cmd_i.k};
    tmp_raddr  = {cmd_i.k, cmd_i.grp[K_W-1:0]};
    if (cmd_i.col_pass) begin
      fac = basis_f(cmd_i.grp[IDX_W-1:K_W], cmd_i.k);
    end else begin
      fac = basis_f(cmd_i.grp[K_W-1:0], cmd_i.k);
    end
  end

  idct_ram #(.WIDTH(COEF_W), .DEPTH(NCOEF)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_we),
    .waddr_i (cmd_i.load_addr),
    .wdata_i (coefficient_i),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  idct_ram #(.WIDTH(TMP_W), .DEPTH(NCOEF)) u_tmp_ram (
    .clk_i   (clk_i),
    .we_i    (tmp_we),
    .waddr_i (grp2_q),
    .wdata_i (tmp_wdata),
    .raddr_i (tmp_raddr),
    .rdata_o (tmp_rdata)
  );

  // Operand select: coefficient in the row pass, row result in the column pass.
  assign mdata = col1_q ? $signed(tmp_rdata)
                        : TMP_W'($signed(coef_rdata));

  // Accumulate; the first product of a group restarts the sum.
  always_comb begin
    sum       = ((k2_q == '0) ? '0 : acc_q) + ACC_W'(prod_q);
    fin       = vld2_q && (k2_q == K_W'(BLK - 1));
    tmp_we    = fin && !col2_q;
    tmp_wdata = sum[TMP_W-1:0];
    shr       = SHR_W'(sum >>> SHIFT);
    lvl       = (SHR_W + 1)'(shr) + (SHR_W + 1)'(128);
    if (lvl > (SHR_W + 1)'(32767)) begin
      sat = 16'sh7fff;
    end else if (lvl < -(SHR_W + 1)'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = lvl[15:0];
    end
  end

  // Pipeline stages: factor and tag, product, accumulator.
  always_ff @(posedge clk_i) begin
    fac1_q <= fac;
    grp1_q <= cmd_i.grp;
    k1_q   <= cmd_i.k;
    col1_q <= cmd_i.col_pass;
    prod_q <= mdata * fac1_q;
    grp2_q <= grp1_q;
    k2_q   <= k1_q;
    col2_q <= col1_q;
    if (vld2_q) begin
      acc_q <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= cmd_i.issue;
      vld2_q <= vld1_q;
    end
  end

  // Output register: filled by a finished column sum, emptied by a beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin && col2_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin && col2_q) begin
      sample_q <= sat;
      last_q   <= (grp2_q == IDX_W'(NCOEF - 1));
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sample_o          = sample_q;
  assign last_sample_o     = last_q;
  assign status_o.out_busy = out_valid_q;

  // A column result never overwrites a sample still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && col2_q) |-> !out_valid_q)
    else $error("column result overwrote a pending sample");

  // Products of one group follow each other without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld1_q && k1_q != '0) |-> $past(cmd_i.issue, 2))
    else $error("gap inside an accumulation group");

  // Row and column products never share one group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld2_q && k2_q != '0) |-> (col2_q == $past(col2_q)))
    else $error("pass changed inside a group");

endmodule

>>> bench/idct_2d_block_unit_test.sv
// Self-checking bench for the 8x8 inverse DCT block: directed and random blocks,
// a fixed-point predictor of its own, and random stalls on both channels.
// Depends on idct_pkg and the RTL of idct_2d_block_unit.
module idct_2d_block_unit_test;
  import idct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] coefficient_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] sample_o;
  logic               last_sample_o;

  idct_2d_block_unit dut (.*);

  always #2 clk_i = ~clk_i;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_sample;
  } sample_beat_t;

  // Predictor state: Q1.14 basis table, coefficient store and load position.
  logic signed [15:0] basis_q14 [BLK][BLK];
  logic signed [15:0] coef_store [NCOEF];
  int                 load_pos;
  sample_beat_t       pending_samples [$];
  int                 errors;
  int                 cycles;
  int                 hold_cycles;
  int                 long_hold;
  bit                 stall_out;

  // Cosine of a Q2.30 angle in [0, pi/2] by a thirteen-term Taylor series.
  function automatic longint cos_q30(longint unsigned a);
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x2   = (a * a) >> 30;
    term = 64'd1 << 30;
    acc  = 64'sd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
    return acc;
  endfunction

  // Fill the basis table with c(q)*cos((2p+1)q*pi/16), rounded to Q1.14.
  function automatic void build_basis();
    int     k;
    int     r;
    bit     neg;
    longint c;
    longint mag;
    for (int p = 0; p < BLK; p++) begin
      for (int q = 0; q < BLK; q++) begin
        if (q == 0) begin
          basis_q14[p][q] = 16'sd11585;
        end else begin
          k   = ((2 * p + 1) * q) % (4 * BLK);
          neg = 1'b0;
          if (k < BLK) r = k;
          else if (k < 2 * BLK) begin r = 2 * BLK - k; neg = 1'b1; end
          else if (k < 3 * BLK) begin r = k - 2 * BLK; neg = 1'b1; end
          else r = 4 * BLK - k;
          c   = cos_q30((64'd3373259426 * r) / (2 * BLK));
          mag = (c + (64'sd1 << 15)) >>> 16;
          basis_q14[p][q] = neg ? -16'(mag) : 16'(mag);
        end
      end
    end
  endfunction

  // Store one coefficient; a full block yields its 64 expected samples.
  function automatic void take_coefficient(logic signed [15:0] coef);
    longint acc;
    longint val;
    sample_beat_t b;
    coef_store[load_pos] = coef;
    load_pos++;
    if (load_pos < NCOEF) return;
    load_pos = 0;
    for (int y = 0; y < BLK; y++) begin
      for (int x = 0; x < BLK; x++) begin
        acc = 0;
        for (int u = 0; u < BLK; u++)
          for (int v = 0; v < BLK; v++)
            acc += longint'(basis_q14[y][u]) * longint'(basis_q14[x][v])
                   * longint'(coef_store[u * BLK + v]);
        val = (acc >>> 30) + 128;
        if (val > 32767) val = 32767;
        if (val < -32768) val = -32768;
        b.sample      = 16'(val);
        b.last_sample = (y == BLK - 1) && (x == BLK - 1);
        pending_samples.push_back(b);
      end
    end
  endfunction

  // Input monitor feeds the predictor with every accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) take_coefficient(coefficient_i);
  end

  // Output checker compares each accepted beat with the oldest expectation.
  always @(posedge clk_i) begin
    sample_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        $error("sample beat with none expected: %0d", sample_o);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        if (sample_o !== want.sample) begin
          $error("sample: expected %0d, actual %0d", want.sample, sample_o);
          errors++;
        end
        if (last_sample_o !== want.last_sample) begin
          $error("last_sample: expected %0d, actual %0d", want.last_sample, last_sample_o);
          errors++;
        end
      end
    end
  end

  // Receiver: long counted hold-off, else ready or, if stalling, mostly short gaps.
  always @(posedge clk_i) begin
    if (long_hold > 0) begin
      hold_cycles <= long_hold;
      long_hold   = 0;
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else if (!stall_out) begin
      out_ready_i <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      out_ready_i <= 1'b0;
      hold_cycles <= $urandom_range(10, 40);
    end else begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL idct_2d_block_unit");
      $finish;
    end
  end

  // Offer one beat and hold it until it is accepted.
  task automatic send_coefficient(logic signed [15:0] coef);
    in_valid_i    <= 1'b1;
    coefficient_i <= coef;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Random sender gap: usually none, sometimes short, rarely long.
  task automatic sender_gap(bit enable);
    int n;
    n = 0;
    if (enable) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: n = $urandom_range(1, 3);
        5:             n = $urandom_range(20, 60);
        default:       n = 0;
      endcase
    end
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drop valid, let the predictor see the last beat, then wait for every sample.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_samples.size() != 0) @(posedge clk_i);
  endtask

  // Directed: a checkerboard at both extremes that saturates.
  task automatic test_directed_blocks();
    for (int i = 0; i < NCOEF; i++) begin
      send_coefficient(((i / BLK + i % BLK) % 2 == 0) ? 16'sh7fff : 16'sh8000);
      sender_gap(1'b1);
    end
    wait_drained();
  endtask

  // Random block under random idling: small, full-range and sparse content.
  task automatic test_random_blocks();
    logic signed [15:0] c;
    stall_out = 1'b1;
    for (int i = 0; i < NCOEF; i++) begin
      case ($urandom_range(0, 2))
        0:       c = 16'($signed($urandom_range(0, 511)) - 256);
        1:       c = 16'($urandom);
        default: c = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'sd0;
      endcase
      send_coefficient(c);
      sender_gap(1'b1);
    end
  endtask

  // Receiver holds off while the sender keeps offering the next block.
  task automatic test_output_backpressure();
    long_hold = 3000;
    for (int i = 0; i < 22; i++) send_coefficient(16'($urandom));
    wait_drained();
    stall_out = 1'b0;
  endtask

  initial begin
    errors      = 0;
    cycles      = 0;
    load_pos    = 0;
    hold_cycles = 0;
    long_hold   = 0;
    stall_out   = 1'b0;
    build_basis();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_blocks();
    test_random_blocks();
    test_output_backpressure();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_samples.size() == 0) begin
      $display("PASS idct_2d_block_unit");
    end else begin
      $display("FAIL idct_2d_block_unit");
    end
    $finish;
  end

endmodule
